>>> rtl/multiplexed_seven_segment_counter_macros.svh
// assertion macros used by the checker file
`ifndef MULTIPLEXED_SEVEN_SEGMENT_COUNTER_MACROS_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_COUNTER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define MSC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define MSC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/msc_pkg.sv
package msc_pkg;

   localparam int DIGITS_DEF = 6;
   localparam int MAX_DIGITS = 8;

   localparam int DIGIT_W = 4;
   localparam int SEG_W   = 7;
   localparam int SEL_W   = 6;
   localparam int POS_W   = 3;
   localparam int CFG_W   = 8;
   localparam int APB_DW  = 32;
   localparam int APB_AW  = 3;

   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   // register map, index is paddr[2]
   localparam logic REG_SLOT_TICKS = 1'b0;
   localparam logic REG_ROUNDS     = 1'b1;

   localparam logic [CFG_W-1:0] SLOT_TICKS_RST = 8'd2;
   localparam logic [CFG_W-1:0] ROUNDS_RST     = 8'd30;

   typedef struct packed {
      logic [SEG_W-1:0] segments;
      logic [SEL_W-1:0] digit_select;
      logic [POS_W-1:0] digit_position;
   } rsp_word_type;

   function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] s;
      case (d)
         4'd0:    s = 7'h3f;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5b;
         4'd3:    s = 7'h4f;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6d;
         4'd6:    s = 7'h7d;
         4'd7:    s = 7'h07;
         4'd8:    s = 7'h7f;
         4'd9:    s = 7'h6f;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

endpackage

>>> rtl/msc_channel_if.sv
interface msc_req_if;
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink   (input valid, input tick, output ready);
endinterface

interface msc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [msc_pkg::SEG_W-1:0]     segments;
   logic [msc_pkg::SEL_W-1:0]     digit_select;
   logic [msc_pkg::POS_W-1:0]     digit_position;

   modport source (output valid, output segments, output digit_select,
                   output digit_position, input ready);
   modport sink   (input valid, input segments, input digit_select,
                   input digit_position, output ready);
endinterface

>>> rtl/msc_digit_cell.sv
// one bcd digit of the count, ripple carry to the next cell
module msc_digit_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         carry_in,
   output logic [msc_pkg::DIGIT_W-1:0]  digit,
   output logic                         carry_out
);

   logic [msc_pkg::DIGIT_W-1:0] digit_ff;
   logic [msc_pkg::DIGIT_W-1:0] digit_in;
   logic                        at_max;

   assign at_max    = (digit_ff >= msc_pkg::DIGIT_MAX);
   assign carry_out = carry_in && at_max;
   assign digit     = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (carry_in) begin
         digit_in = at_max ? '0 : digit_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else begin
         digit_ff <= digit_in;
      end
   end

endmodule

>>> rtl/msc_out_buf.sv
// output register with a skid stage behind it
module msc_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  msc_pkg::rsp_word_type word_in,
   output logic                  full,
   msc_rsp_if.source             rsp_chan
);

   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   msc_pkg::rsp_word_type out_word_ff, out_word_in;
   msc_pkg::rsp_word_type skid_word_ff, skid_word_in;
   logic                  load_out;

   assign load_out = !out_valid_ff || rsp_chan.ready;
   assign full     = skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (load_out) begin
         if (skid_valid_ff) begin
            out_word_in = skid_word_ff;
         end else begin
            out_word_in = word_in;
         end
         out_valid_in  = skid_valid_ff || push;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_word_in  = word_in;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.segments       = out_word_ff.segments;
   assign rsp_chan.digit_select   = out_word_ff.digit_select;
   assign rsp_chan.digit_position = out_word_ff.digit_position;

endmodule

>>> rtl/multiplexed_seven_segment_counter.sv
// accepted words go to the output register, or to the skid stage on a stall
// throughput: one word per cycle while the skid stage is empty; the counters
//   and the carry ripple through the digit cells are combinational
// reset: synchronous, clears the count, scan position, both counters and the
//   output stage; slot_ticks returns to 2 and rounds_per_count to 30
module multiplexed_seven_segment_counter #(
   parameter int DIGITS = msc_pkg::DIGITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   msc_req_if.sink                      req_chan,
   msc_rsp_if.source                    rsp_chan,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [msc_pkg::APB_AW-1:0]   paddr,
   input  logic [msc_pkg::APB_DW-1:0]   pwdata,
   output logic [msc_pkg::APB_DW-1:0]   prdata,
   output logic                         pready
);

   // last scan position, as a position code
   localparam logic [msc_pkg::POS_W-1:0] POS_LAST = msc_pkg::POS_W'(DIGITS - 1);

   // configuration registers
   logic [msc_pkg::CFG_W-1:0] slot_ticks_ff, slot_ticks_in;
   logic [msc_pkg::CFG_W-1:0] rounds_ff, rounds_in;
   logic                      cfg_write;

   // scan state
   logic [msc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [msc_pkg::CFG_W-1:0] slot_cnt_ff, slot_cnt_in, slot_next;
   logic [msc_pkg::CFG_W-1:0] round_cnt_ff, round_cnt_in, round_next;
   logic                      slot_end, round_end, pos_last;

   // handshake and stepping
   logic                      accept, advance, scan_wrap, count_inc;
   logic                      buf_full;

   // digit row
   logic [msc_pkg::DIGIT_W-1:0] digits [DIGITS];
   logic [DIGITS-1:0]           carry;
   logic [msc_pkg::DIGIT_W-1:0] shown_digit;
   logic [msc_pkg::SEL_W+1:0]   sel_wide;
   logic [msc_pkg::POS_W-1:0]   sel_bit;
   msc_pkg::rsp_word_type       word;

   // ---------------------------------------------------------------- apb port
   // always ready, write lands on the access cycle
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      slot_ticks_in = slot_ticks_ff;
      rounds_in     = rounds_ff;
      if (cfg_write) begin
         case (paddr[2])
            msc_pkg::REG_SLOT_TICKS: slot_ticks_in = pwdata[msc_pkg::CFG_W-1:0];
            msc_pkg::REG_ROUNDS:     rounds_in     = pwdata[msc_pkg::CFG_W-1:0];
            default:                 slot_ticks_in = slot_ticks_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         msc_pkg::REG_SLOT_TICKS: prdata = msc_pkg::APB_DW'(slot_ticks_ff);
         msc_pkg::REG_ROUNDS:     prdata = msc_pkg::APB_DW'(rounds_ff);
         default:                 prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- stepping
   // a new word is taken whenever the skid stage is empty
   assign req_chan.ready = !buf_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign advance        = accept && req_chan.tick;

   // counters compare after the 8-bit increment; a zero register acts as one,
   // and a counter at or past a lowered limit ends on the next tick
   assign slot_next  = slot_cnt_ff + 8'd1;
   assign slot_end   = (slot_next >= slot_ticks_ff) || (slot_next == '0);
   assign pos_last   = (pos_ff == POS_LAST);
   assign scan_wrap  = advance && slot_end && pos_last;
   assign round_next = round_cnt_ff + 8'd1;
   assign round_end  = (round_next >= rounds_ff) || (round_next == '0);
   assign count_inc  = scan_wrap && round_end;

   always_comb begin
      slot_cnt_in  = slot_cnt_ff;
      pos_in       = pos_ff;
      round_cnt_in = round_cnt_ff;
      if (advance) begin
         slot_cnt_in = slot_end ? '0 : slot_next;
         if (slot_end) begin
            pos_in = pos_last ? '0 : pos_ff + 3'd1;
         end
      end
      if (scan_wrap) begin
         round_cnt_in = round_end ? '0 : round_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ticks_ff <= msc_pkg::SLOT_TICKS_RST;
         rounds_ff     <= msc_pkg::ROUNDS_RST;
         pos_ff        <= '0;
         slot_cnt_ff   <= '0;
         round_cnt_ff  <= '0;
      end else begin
         slot_ticks_ff <= slot_ticks_in;
         rounds_ff     <= rounds_in;
         pos_ff        <= pos_in;
         slot_cnt_ff   <= slot_cnt_in;
         round_cnt_ff  <= round_cnt_in;
      end
   end

   // ---------------------------------------------------------------- digit row
   // ones digit is cell 0; the carry ripples up one cell per digit
   assign carry[0] = count_inc;

   for (genvar k = 0; k < DIGITS; k++) begin : g_cell
      if (k < DIGITS - 1) begin : g_mid
         msc_digit_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .carry_in  (carry[k]),
            .digit     (digits[k]),
            .carry_out (carry[k+1])
         );
      end else begin : g_top
         // carry out of the top digit is the wrap to all zeros, dropped
         msc_digit_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .carry_in  (carry[k]),
            .digit     (digits[k]),
            .carry_out ()
         );
      end
   end

   // ---------------------------------------------------------------- result word
   // shows the state before this word's tick is applied
   always_comb begin
      shown_digit = '0;
      for (int k = 0; k < DIGITS; k++) begin
         if (pos_ff == msc_pkg::POS_W'(k)) begin
            shown_digit = digits[k];
         end
      end
   end

   // select bit for position p is DIGITS-1-p; bits above the field fall off
   assign sel_bit  = POS_LAST - pos_ff;
   assign sel_wide = ~((msc_pkg::SEL_W+2)'(1) << sel_bit);

   always_comb begin
      word.segments       = msc_pkg::seg_decode(shown_digit);
      word.digit_select   = sel_wide[msc_pkg::SEL_W-1:0];
      word.digit_position = pos_ff;
   end

   msc_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .word_in  (word),
      .full     (buf_full),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> rtl/msc_checker.sv
`include "multiplexed_seven_segment_counter_macros.svh"

module msc_checker #(
   parameter int DIGITS = msc_pkg::DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   msc_req_if.sink     req_chan,
   msc_rsp_if.source   rsp_chan
);

   logic                  rsp_stall;
   logic                  pos_ok;
   int                    sel_ones;
   msc_pkg::rsp_word_type rsp_word;

   assign rsp_stall = rsp_chan.valid && !rsp_chan.ready;
   assign rsp_word  = {rsp_chan.segments, rsp_chan.digit_select, rsp_chan.digit_position};
   assign sel_ones  = $countones(rsp_chan.digit_select);
   assign pos_ok    = int'(rsp_chan.digit_position) < DIGITS;

   `MSC_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_chan.valid && $stable(rsp_word), "word changed")
   `MSC_ASSERT_NOW(a_stall_only_full, !req_chan.ready, rsp_chan.valid, "stall with empty output")
   `MSC_ASSERT_NOW(a_one_select, rsp_chan.valid, sel_ones >= 5, "two digits selected")
   `MSC_ASSERT_NOW(a_pos_range, rsp_chan.valid, pos_ok, "position out of range")

endmodule

bind multiplexed_seven_segment_counter msc_checker #(.DIGITS(DIGITS)) u_msc_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

>>> tb/sv/multiplexed_seven_segment_counter_test.sv
`timescale 1ns / 1ps

module multiplexed_seven_segment_counter_test;
   import msc_pkg::*;

   localparam int NUM_DIGITS = DIGITS_DEF;
   localparam int IDLE_PCT   = 31;     // chance in a hundred that a side idles
   localparam int MAX_REPORTS = 10;

   // segment patterns for digits 9 down to 0, digit d at bits [7d +: 7]
   localparam logic [10*SEG_W-1:0] GLYPH_ROM = {
      7'h6f, 7'h7f, 7'h07, 7'h7d, 7'h6d, 7'h66, 7'h4f, 7'h5b, 7'h06, 7'h3f
   };

   logic clock;
   logic reset;

   // apb-style register port
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [APB_AW-1:0] paddr;
   logic [APB_DW-1:0] pwdata;
   logic [APB_DW-1:0] prdata;
   logic              pready;

   msc_req_if req_if();
   msc_rsp_if rsp_if();

   multiplexed_seven_segment_counter #(
      .DIGITS(NUM_DIGITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // tick values still to be offered on the request channel
   bit pending_ticks[$];
   // display words the block owes us, oldest first
   rsp_word_type shown_words[$];

   // mirror of the display state: bcd count, scan slot and the two dividers
   logic [DIGIT_W-1:0] count_bcd [NUM_DIGITS];
   logic [POS_W-1:0]   scan_pos;
   logic [CFG_W-1:0]   slot_cnt;
   logic [CFG_W-1:0]   round_cnt;
   // mirror of the two registers
   logic [CFG_W-1:0]   slot_len;
   logic [CFG_W-1:0]   round_len;

   logic req_taken;        // request word accepted at the last rising edge
   bit   no_gaps  = 1'b0;  // both sides run flat out while set
   int   failures = 0;
   int   words_seen = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic void note_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("%s", what);
   endfunction

   // work out the word shown for this tick, then advance the display state
   task automatic step_display(input logic tick_in);
      rsp_word_type w;
      logic [SEL_W-1:0] lit;
      logic carry;
      // outputs reflect the state before the tick lands
      w.segments = GLYPH_ROM[count_bcd[scan_pos]*SEG_W +: SEG_W];
      lit = '0;
      lit[NUM_DIGITS-1-scan_pos] = 1'b1;
      w.digit_select   = ~lit;      // active low, ones digit on the top bit
      w.digit_position = scan_pos;
      shown_words.push_back(w);
      if (tick_in) begin
         slot_cnt = slot_cnt + 1'b1;
         // a zero length behaves as one; a length lowered under the counter ends the slot now
         if (slot_cnt >= slot_len || slot_cnt == '0) begin
            slot_cnt = '0;
            if (scan_pos == POS_W'(NUM_DIGITS - 1)) begin
               scan_pos  = '0;
               round_cnt = round_cnt + 1'b1;
               if (round_cnt >= round_len || round_cnt == '0) begin
                  round_cnt = '0;
                  // bcd ripple, all nines roll over to zero
                  carry = 1'b1;
                  for (int k = 0; k < NUM_DIGITS; k++) begin
                     if (carry) begin
                        if (count_bcd[k] == DIGIT_MAX) begin
                           count_bcd[k] = '0;
                        end else begin
                           count_bcd[k] = count_bcd[k] + 1'b1;
                           carry = 1'b0;
                        end
                     end
                  end
               end
            end else begin
               scan_pos = scan_pos + 1'b1;
            end
         end
      end
   endtask

   // rising edge: record accepted ticks, check returned words
   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (reset) begin
         req_taken <= 1'b0;
         for (int k = 0; k < NUM_DIGITS; k++) count_bcd[k] = '0;
         scan_pos  = '0;
         slot_cnt  = '0;
         round_cnt = '0;
         slot_len  = SLOT_TICKS_RST;
         round_len = ROUNDS_RST;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) step_display(req_if.tick);
         if (rsp_if.valid && rsp_if.ready) begin
            words_seen++;
            if (shown_words.size() == 0) begin
               note_failure($sformatf("word %0d not expected: seg %h sel %h pos %0d",
                  words_seen, rsp_if.segments, rsp_if.digit_select, rsp_if.digit_position));
            end else begin
               want = shown_words.pop_front();
               if (rsp_if.segments !== want.segments ||
                   rsp_if.digit_select !== want.digit_select ||
                   rsp_if.digit_position !== want.digit_position) begin
                  note_failure($sformatf(
                     "word %0d: seg %h/%h sel %h/%h pos %0d/%0d (expected/actual)",
                     words_seen, want.segments, rsp_if.segments, want.digit_select,
                     rsp_if.digit_select, want.digit_position, rsp_if.digit_position));
               end
            end
         end
      end
   end

   // falling edge: offer the next tick and throttle the result side
   always @(negedge clock) begin : feed
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.tick  <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
         // a word on offer stays put until it is taken
         if (!req_if.valid || req_taken) begin
            if (pending_ticks.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
               req_if.valid <= 1'b1;
               req_if.tick  <= pending_ticks.pop_front();
            end else begin
               req_if.valid <= 1'b0;
               req_if.tick  <= 1'($urandom_range(1));
            end
         end
      end
   end

   // register write in setup and access phases; the mirror follows once the access has landed
   task automatic write_csr(input logic idx, input logic [CFG_W-1:0] value);
      logic [APB_DW-1:0] data;
      data = $urandom();          // bits above the register are junk
      data[CFG_W-1:0] = value;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_SLOT_TICKS) slot_len = value;
      else round_len = value;
   endtask

   // wait for every queued tick to go in and every owed word to come back
   task automatic settle();
      do @(posedge clock);
      while (pending_ticks.size() != 0 || req_if.valid || shown_words.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] slot, input logic [CFG_W-1:0] rounds,
                            input int items, input int tick_pct);
      write_csr(REG_SLOT_TICKS, slot);
      write_csr(REG_ROUNDS, rounds);
      repeat (items) pending_ticks.push_back($urandom_range(99) < tick_pct);
      settle();
   endtask

   // register settings, weighted toward short dividers so the count keeps moving
   function automatic logic [CFG_W-1:0] pick_setting();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         2, 3:    return CFG_W'(1);
         default: return CFG_W'($urandom_range(2, 12));
      endcase
   endfunction

   initial begin : stimulus
      reset        = 1'b1;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      req_if.valid = 1'b0;
      req_if.tick  = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: idle words hold the display, then one full scan
      repeat (2) pending_ticks.push_back(1'b0);
      repeat (12) pending_ticks.push_back(1'b1);
      settle();

      // zero in both registers acts as one: a count step every six ticks
      run_phase('0, '0, 11, 100);

      // long slot builds the slot counter up, then a short slot cuts it off
      run_phase('1, '1, 200, 95);
      run_phase(CFG_W'(3), '1, 60, 100);

      // many rounds build the round counter up, then a short round count cuts it off
      run_phase(CFG_W'(1), '1, 200, 90);
      run_phase(CFG_W'(1), CFG_W'(2), 60, 100);

      // flat-out stretch with the fastest settings pushes carries into the tens
      no_gaps = 1'b1;
      run_phase(CFG_W'(1), CFG_W'(1), 400, 100);
      no_gaps = 1'b0;

      for (int p = 0; p < 10; p++)
         run_phase(pick_setting(), pick_setting(), 110, $urandom_range(50, 100));

      repeat (8) @(negedge clock);
      if (failures == 0) $display("multiplexed_seven_segment_counter: match");
      else $display("multiplexed_seven_segment_counter: mismatch");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #4_000_000;
      $display("multiplexed_seven_segment_counter: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/msc_pkg.sv
rtl/msc_channel_if.sv
rtl/msc_digit_cell.sv
rtl/msc_out_buf.sv
rtl/multiplexed_seven_segment_counter.sv
rtl/msc_checker.sv
tb/sv/multiplexed_seven_segment_counter_test.sv
